@@ hw/rtl/hwa_pkg.sv @@
// Shared constants, types and the hydropathy lookup for the window average block.
package hwa_pkg;

  localparam int CODE_W         = 5;
  localparam int VAL_W          = 10;
  localparam int WIN_W          = 6;
  localparam int SUM_W          = 15;
  localparam int MAG_W          = 14;
  localparam int MEAN_W         = 10;
  localparam int J_W            = 4;
  localparam int CNT_W          = 4;
  localparam int MAX_WINDOW_DEF = 32;
  localparam int WIN_LIMIT      = 32;
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(10);
  localparam logic [WIN_W-1:0] WIN_MIN   = WIN_W'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_POS,
    ST_DIV,
    ST_EMIT,
    ST_NEXT,
    ST_FL_CHECK,
    ST_FL_SUB
  } state_e;

  typedef struct packed {
    logic idle;
    logic latch_in;
    logic push;
    logic rd_flush;
    logic flush_sub;
    logic div_start;
    logic out_load;
    logic j_inc;
    logic clear_seq;
  } cmd_t;

  typedef struct packed {
    logic flush;
    logic pos_emit;
    logic pos_full;
    logic sub_needed;
    logic j_last;
    logic div_busy;
    logic out_free;
  } stat_t;

  // Kyte-Doolittle scale in hundredths, codes past X read as zero
  function automatic logic signed [VAL_W-1:0] kd_value(input logic [CODE_W-1:0] code);
    logic signed [VAL_W-1:0] v;
    case (code)
      5'd0:    v = 10'sd180;
      5'd1:    v = 10'sd250;
      5'd2:    v = -10'sd350;
      5'd3:    v = -10'sd350;
      5'd4:    v = 10'sd280;
      5'd5:    v = -10'sd40;
      5'd6:    v = -10'sd320;
      5'd7:    v = 10'sd450;
      5'd8:    v = -10'sd390;
      5'd9:    v = 10'sd380;
      5'd10:   v = 10'sd190;
      5'd11:   v = -10'sd350;
      5'd12:   v = -10'sd160;
      5'd13:   v = -10'sd350;
      5'd14:   v = -10'sd450;
      5'd15:   v = -10'sd80;
      5'd16:   v = -10'sd70;
      5'd17:   v = 10'sd420;
      5'd18:   v = -10'sd90;
      5'd19:   v = -10'sd130;
      5'd20:   v = -10'sd49;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/hwa_res_if.sv @@
// Residue input channel.
interface hwa_res_if;
  import hwa_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] residue_code;
  logic              seq_end;

  modport source (output valid, output residue_code, output seq_end, input ready);
  modport sink   (input valid, input residue_code, input seq_end, output ready);
endinterface

@@ hw/rtl/hwa_mean_if.sv @@
// Window mean result channel.
interface hwa_mean_if;
  import hwa_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [MEAN_W-1:0] window_mean;
  logic                     run_last;

  modport source (output valid, output window_mean, output run_last, input ready);
  modport sink   (input valid, input window_mean, input run_last, output ready);
endinterface

@@ hw/rtl/hwa_cfg_if.sv @@
// Window size configuration write channel.
interface hwa_cfg_if;
  import hwa_pkg::*;
  logic             valid;
  logic             ready;
  logic [WIN_W-1:0] window_size;

  modport source (output valid, output window_size, input ready);
  modport sink   (input valid, input window_size, output ready);
endinterface

@@ hw/rtl/hwa_ram.sv @@
// Generic single write port RAM with registered read.
module hwa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

@@ hw/rtl/hwa_ctrl.sv @@
// Sequencer for push, flush, divide and result handoff.
module hwa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  hwa_pkg::stat_t stat_i,
  output hwa_pkg::cmd_t  cmd_o
);
  import hwa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.idle = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = stat_i.flush ? ST_FL_CHECK : ST_POS;
      end
      ST_FL_CHECK: begin
        cmd_o.rd_flush = 1'b1;
        state_d        = stat_i.sub_needed ? ST_FL_SUB : ST_POS;
      end
      ST_FL_SUB: begin
        cmd_o.flush_sub = 1'b1;
        state_d         = ST_POS;
      end
      ST_POS: begin
        if (stat_i.pos_emit) begin
          if (stat_i.pos_full) begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV;
          end else begin
            state_d = ST_EMIT;
          end
        end else begin
          state_d = stat_i.flush ? ST_NEXT : ST_IDLE;
        end
      end
      ST_DIV: begin
        if (!stat_i.div_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = stat_i.flush ? ST_NEXT : ST_IDLE;
        end
      end
      ST_NEXT: begin
        if (stat_i.j_last) begin
          cmd_o.clear_seq = 1'b1;
          state_d         = ST_IDLE;
        end else begin
          cmd_o.j_inc = 1'b1;
          state_d     = ST_FL_CHECK;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end
endmodule

@@ hw/rtl/hwa_datapath.sv @@
// Window ring, running sum, serial divider and output register.
module hwa_datapath #(
  parameter int MAX_WINDOW = hwa_pkg::MAX_WINDOW_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  hwa_pkg::cmd_t                    cmd_i,
  output hwa_pkg::stat_t                   stat_o,
  input  logic [hwa_pkg::CODE_W-1:0]       residue_code_i,
  input  logic                             seq_end_i,
  input  logic                             cfg_we_i,
  input  logic [hwa_pkg::WIN_W-1:0]        cfg_data_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic signed [hwa_pkg::MEAN_W-1:0] window_mean_o,
  output logic                             run_last_o
);
  import hwa_pkg::*;

  localparam int AW      = $clog2(MAX_WINDOW);
  localparam int PW      = ((AW > WIN_W) ? AW : WIN_W) + 1;
  localparam int WIN_CAP = (MAX_WINDOW < WIN_LIMIT) ? MAX_WINDOW : WIN_LIMIT;

  logic [WIN_W-1:0]        win_q;
  logic signed [VAL_W-1:0] v_q;
  logic                    flush_q;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [WIN_W-1:0]        seen_q, seen_d;
  logic [AW-1:0]           wp_q;
  logic [WIN_W-1:0]        c0_q;
  logic [J_W-1:0]          j_q;
  logic [WIN_W-1:0]        rem_q;
  logic [MAG_W-1:0]        quo_q;
  logic                    neg_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    busy_q;
  logic                    out_valid_q;
  logic signed [MEAN_W-1:0] mean_q;
  logic                    last_q;

  logic [WIN_W-1:0]        ahead;
  logic [WIN_W:0]          pos;
  logic [WIN_W-1:0]        rd_off;
  logic [PW-1:0]           rd_diff;
  logic [AW-1:0]           raddr;
  logic [VAL_W-1:0]        rdata;
  logic signed [SUM_W-1:0] rd_ext;
  logic                    full_win;
  logic [WIN_W-1:0]        cfg_sat;
  logic [WIN_W:0]          shifted;
  logic                    ge;
  logic [MEAN_W-1:0]       q_lo;
  logic signed [MEAN_W-1:0] div_mean;
  logic [SUM_W-1:0]        sum_abs;
  logic                    j_last;

  assign ahead    = win_q - (win_q >> 1);
  assign pos      = flush_q ? ({1'b0, c0_q} + (WIN_W+1)'(j_q)) : {1'b0, seen_q};
  assign full_win = seen_q >= win_q;
  assign j_last   = (WIN_W'(j_q)) == (ahead - WIN_W'(1));

  // ring read address: write pointer minus window or fill, modulo ring size
  assign rd_off  = cmd_i.rd_flush ? seen_q : win_q;
  always_comb begin
    rd_diff = PW'(wp_q) - PW'(rd_off);
    if (rd_diff[PW-1]) begin
      rd_diff = rd_diff + PW'(MAX_WINDOW);
    end
  end
  assign raddr  = rd_diff[AW-1:0];
  assign rd_ext = SUM_W'($signed(rdata));

  hwa_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (wp_q),
    .wdata_i (v_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign cfg_sat = (cfg_data_i > WIN_W'(WIN_CAP)) ? WIN_W'(WIN_CAP) : cfg_data_i;

  always_comb begin
    sum_d  = sum_q;
    seen_d = seen_q;
    if (cmd_i.push) begin
      sum_d  = sum_q - (full_win ? rd_ext : '0) + SUM_W'(v_q);
      seen_d = full_win ? win_q : seen_q + WIN_W'(1);
    end else if (cmd_i.flush_sub) begin
      sum_d  = sum_q - rd_ext;
      seen_d = seen_q - WIN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= WIN_RESET;
      sum_q   <= '0;
      seen_q  <= '0;
      wp_q    <= '0;
      flush_q <= 1'b0;
      c0_q    <= '0;
      j_q     <= '0;
    end else begin
      if (cfg_we_i && (cfg_data_i >= WIN_MIN)) begin
        win_q  <= cfg_sat;
        sum_q  <= '0;
        seen_q <= '0;
        wp_q   <= '0;
      end else if (cmd_i.clear_seq) begin
        sum_q  <= '0;
        seen_q <= '0;
        wp_q   <= '0;
      end else begin
        sum_q  <= sum_d;
        seen_q <= seen_d;
        if (cmd_i.push) begin
          wp_q <= (wp_q == AW'(MAX_WINDOW - 1)) ? '0 : wp_q + AW'(1);
        end
      end
      if (cmd_i.latch_in) begin
        flush_q <= seq_end_i;
      end
      if (cmd_i.push) begin
        c0_q <= seen_d;
        j_q  <= '0;
      end else if (cmd_i.j_inc) begin
        j_q <= j_q + J_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      v_q <= kd_value(residue_code_i);
    end
  end

  // restoring divider on the magnitude, one quotient bit per cycle
  assign sum_abs = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign shifted = {rem_q, quo_q[MAG_W-1]};
  assign ge      = shifted >= {1'b0, win_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(MAG_W - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= sum_abs[MAG_W-1:0];
      neg_q <= sum_q[SUM_W-1];
    end else if (busy_q) begin
      rem_q <= ge ? WIN_W'(shifted - {1'b0, win_q}) : shifted[WIN_W-1:0];
      quo_q <= {quo_q[MAG_W-2:0], ge};
    end
  end

  assign q_lo     = quo_q[MEAN_W-1:0];
  assign div_mean = neg_q ? $signed(-q_lo) : $signed(q_lo);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      mean_q <= (pos >= {1'b0, win_q}) ? div_mean : '0;
      last_q <= flush_q && j_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign window_mean_o = mean_q;
  assign run_last_o    = last_q;

  assign stat_o.flush      = flush_q;
  assign stat_o.pos_emit   = pos >= {1'b0, ahead};
  assign stat_o.pos_full   = pos >= {1'b0, win_q};
  assign stat_o.sub_needed = (j_q != '0) && (seen_q > (win_q - WIN_W'(j_q)));
  assign stat_o.j_last     = j_last;
  assign stat_o.div_busy   = busy_q;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;
endmodule

@@ hw/rtl/hydropathy_window_average.sv @@
// Sliding-window Kyte-Doolittle hydropathy mean, one residue per transfer.
// Input ready is high only in idle, so a new residue is taken only after the last one is done.
// A result with a full window goes through the 14-step restoring divider; otherwise the mean is zero.
// Final residue: up to W - W/2 results, paced by divider and result port.
// Reset: asynchronous, active low; window size returns to 10 and the sequence state clears.
// The history ring is not cleared: entries are only read after being written in a sequence.
module hydropathy_window_average #(
  parameter int MAX_WINDOW = hwa_pkg::MAX_WINDOW_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  hwa_res_if.sink           res_i,
  hwa_mean_if.source        mean_o,
  hwa_cfg_if.sink           cfg_i
);
  import hwa_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  cfg_we;

  hwa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (res_i.valid),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  assign res_i.ready = cmd.idle;
  assign cfg_i.ready = cmd.idle;
  assign cfg_we      = cfg_i.valid && cmd.idle;

  hwa_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .residue_code_i (res_i.residue_code),
    .seq_end_i      (res_i.seq_end),
    .cfg_we_i       (cfg_we),
    .cfg_data_i     (cfg_i.window_size),
    .out_ready_i    (mean_o.ready),
    .out_valid_o    (mean_o.valid),
    .window_mean_o  (mean_o.window_mean),
    .run_last_o     (mean_o.run_last)
  );
endmodule

@@ hw/rtl/hwa_checker.sv @@
// Port-level assertions for the hydropathy window average block.
module hwa_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              res_valid_i,
  input logic                              res_ready_i,
  input logic                              cfg_ready_i,
  input logic                              mean_valid_i,
  input logic                              mean_ready_i,
  input logic signed [hwa_pkg::MEAN_W-1:0] window_mean_i,
  input logic                              run_last_i
);
  import hwa_pkg::*;

  // one residue at a time: ready drops right after a transfer
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i |=> !res_ready_i)
    else $error("input ready high right after a transfer");

  a_cfg_with_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i == res_ready_i)
    else $error("config ready differs from input ready");

  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mean_valid_i |-> (window_mean_i >= -10'sd450) && (window_mean_i <= 10'sd450))
    else $error("window mean out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mean_valid_i && !mean_ready_i |=> mean_valid_i && $stable(window_mean_i) &&
      $stable(run_last_i))
    else $error("stalled result changed");
endmodule

bind hydropathy_window_average hwa_checker u_hwa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_i.valid),
  .res_ready_i   (res_i.ready),
  .cfg_ready_i   (cfg_i.ready),
  .mean_valid_i  (mean_o.valid),
  .mean_ready_i  (mean_o.ready),
  .window_mean_i (mean_o.window_mean),
  .run_last_i    (mean_o.run_last)
);
